// ===== rtl/core/cti_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cti_pkg: shared types and constants for the correction table lookup
// Field widths, table geometry, register indexes, opcodes and the structs
// that travel between the table, remainder and configuration units.
// ----------------------------------------------------------------------------
package cti_pkg;

  // Table geometry.
  localparam int TABLE_DEPTH = 512;
  localparam int TBL_AW      = $clog2(TABLE_DEPTH);
  localparam int N_W         = TBL_AW + 1;

  // Field widths.
  localparam int OPCODE_W  = 1;
  localparam int EIDX_W    = 9;
  localparam int ENTRY_W   = 24;
  localparam int ANGLE_W   = 20;
  localparam int CORR_W    = 24;
  localparam int LIDX_W    = 9;
  localparam int SIZE_W    = 10;
  localparam int SPR_W     = 24;
  localparam int OFS_W     = 25;
  localparam int SCALE_W   = 25;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 25;

  // Datapath widths. The table position carries FRAC_W fraction bits.
  localparam int FRAC_W = 16;
  localparam int PROD_W = ANGLE_W + SPR_W + 1;
  localparam int P_W    = 29;
  localparam int Q_W    = P_W - FRAC_W;
  localparam int MAG_W  = Q_W - 1;
  localparam int DIFF_W = ENTRY_W + 1;
  localparam int V_W    = DIFF_W + FRAC_W + 1;
  localparam int V8_W   = 32;
  localparam int SC_W   = V8_W + SCALE_W + 1;
  localparam int C_W    = SC_W - 32;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS_PER_RAD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_OFFSET = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_SCALE = 2'd3;

  // Register reset values.
  localparam logic [SIZE_W-1:0]  RST_TABLE_SIZE   = 10'd360;
  localparam logic [SPR_W-1:0]   RST_STEPS_PER_RAD = 24'd3754936;
  localparam logic [OFS_W-1:0]   RST_INDEX_OFFSET = 25'd32768;
  localparam logic [SCALE_W-1:0] RST_OUTPUT_SCALE = 25'd292812;

  // Opcodes.
  localparam logic [OPCODE_W-1:0] OP_WRITE  = 1'b0;
  localparam logic [OPCODE_W-1:0] OP_LOOKUP = 1'b1;

  typedef struct packed {
    logic [OPCODE_W-1:0]       opcode;
    logic [EIDX_W-1:0]         entry_index;
    logic signed [ENTRY_W-1:0] entry_value;
    logic signed [ANGLE_W-1:0] angle;
  } in_word_t;

  typedef struct packed {
    logic signed [CORR_W-1:0] correction;
    logic [LIDX_W-1:0]        low_index;
  } out_word_t;

  typedef struct packed {
    logic [N_W-1:0]     n_eff;
    logic [SPR_W-1:0]   steps_per_radian;
    logic [OFS_W-1:0]   index_offset;
    logic [SCALE_W-1:0] output_scale;
  } cfg_regs_t;

  typedef struct packed {
    logic               we;
    logic [TBL_AW-1:0]  addr;
    logic [ENTRY_W-1:0] wdata;
  } tbl_req_t;

  typedef struct packed {
    logic             start;
    logic [MAG_W-1:0] mag;
    logic             neg;
    logic [N_W-1:0]   n;
  } mod_req_t;

  typedef struct packed {
    logic              done;
    logic [TBL_AW-1:0] rem;
  } mod_rsp_t;

endpackage
`default_nettype wire

// ===== rtl/core/cti_cfg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cti_cfg: configuration registers
// Holds the four lookup registers and derives the effective table size.
// ----------------------------------------------------------------------------
module cti_cfg (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [cti_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [cti_pkg::CFG_DATA_W-1:0] cfg_data,
  output cti_pkg::cfg_regs_t                 regs
);
  import cti_pkg::*;

  logic [SIZE_W-1:0]  size_r;
  logic [SPR_W-1:0]   spr_r;
  logic [OFS_W-1:0]   ofs_r;
  logic [SCALE_W-1:0] scale_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= RST_TABLE_SIZE;
      spr_r   <= RST_STEPS_PER_RAD;
      ofs_r   <= RST_INDEX_OFFSET;
      scale_r <= RST_OUTPUT_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_TABLE_SIZE:    size_r  <= cfg_data[SIZE_W-1:0];
        CFG_STEPS_PER_RAD: spr_r   <= cfg_data[SPR_W-1:0];
        CFG_INDEX_OFFSET:  ofs_r   <= cfg_data[OFS_W-1:0];
        CFG_OUTPUT_SCALE:  scale_r <= cfg_data[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  // A size of zero behaves as one entry; a size past the depth is clipped.
  always_comb begin
    if (size_r == '0) begin
      regs.n_eff = N_W'(1);
    end else if (int'(size_r) > TABLE_DEPTH) begin
      regs.n_eff = N_W'(TABLE_DEPTH);
    end else begin
      regs.n_eff = N_W'(size_r);
    end
    regs.steps_per_radian = spr_r;
    regs.index_offset     = ofs_r;
    regs.output_scale     = scale_r;
  end

endmodule
`default_nettype wire

// ===== rtl/core/cti_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cti_table: correction table storage
// Single-port synchronous memory with registered read data, swept to zero
// one entry per cycle after reset.
// ----------------------------------------------------------------------------
module cti_table (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire cti_pkg::tbl_req_t           req,
  output logic [cti_pkg::ENTRY_W-1:0]      rd_data,
  output logic                             clr_done
);
  import cti_pkg::*;

  logic [ENTRY_W-1:0] mem [TABLE_DEPTH];
  logic [N_W-1:0]     clr_cnt_r;
  logic               we;
  logic [TBL_AW-1:0]  addr;
  logic [ENTRY_W-1:0] wdata;

  assign clr_done = clr_cnt_r[TBL_AW];

  always_comb begin
    if (!clr_done) begin
      we    = 1'b1;
      addr  = clr_cnt_r[TBL_AW-1:0];
      wdata = '0;
    end else begin
      we    = req.we;
      addr  = req.addr;
      wdata = req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (!clr_done) begin
      clr_cnt_r <= clr_cnt_r + N_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rd_data <= mem[addr];
  end

endmodule
`default_nettype wire

// ===== rtl/core/cti_mod.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cti_mod: bit-serial remainder unit
// Reduces the signed whole-step table position modulo the table size,
// one quotient bit per cycle, and returns a non-negative remainder.
// ----------------------------------------------------------------------------
module cti_mod (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cti_pkg::mod_req_t req,
  output cti_pkg::mod_rsp_t rsp
);
  import cti_pkg::*;

  localparam int CNT_W = $clog2(MAG_W + 1);

  logic              active_r;
  logic              fin_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [MAG_W-1:0]  dvd_r;
  logic [TBL_AW-1:0] rem_r;
  logic              neg_r;
  logic [N_W-1:0]    n_r;
  logic [N_W-1:0]    trial;
  logic [TBL_AW-1:0] rem_nxt;

  always_comb begin
    trial = {rem_r, dvd_r[MAG_W-1]};
    if (trial >= n_r) begin
      rem_nxt = TBL_AW'(trial - n_r);
    end else begin
      rem_nxt = TBL_AW'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      fin_r    <= 1'b0;
    end else begin
      fin_r <= 1'b0;
      if (req.start) begin
        rem_r    <= '0;
        dvd_r    <= req.mag;
        neg_r    <= req.neg;
        n_r      <= req.n;
        cnt_r    <= CNT_W'(MAG_W);
        active_r <= 1'b1;
      end else if (active_r) begin
        rem_r <= rem_nxt;
        dvd_r <= dvd_r << 1;
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          active_r <= 1'b0;
          fin_r    <= 1'b1;
        end
      end
    end
  end

  // A negative position with a nonzero remainder folds back from the top.
  always_comb begin
    rsp.done = fin_r;
    if (neg_r && (rem_r != '0)) begin
      rsp.rem = TBL_AW'(n_r - N_W'(rem_r));
    end else begin
      rsp.rem = rem_r;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/circular_table_interp_lookup.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// circular_table_interp_lookup: circular correction table with interpolation
// Stores pointing corrections by axis angle and returns the linearly
// interpolated correction for a lookup angle.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. A write word stores
// one table entry in the cycle it is taken and leaves busy low, so writes can
// follow each other every cycle. A lookup word keeps busy high until it has
// produced one result word on out_word, marked by out_strobe for exactly
// one cycle; the receiver cannot hold it off, so it must capture the word in
// that cycle. Most of the lookup time is the bit-serial remainder unit, which
// folds the table position into the table size; the two neighboring entries
// are then read one after the other through the single memory port, and the
// interpolation and output scaling each take a multiplier stage. After reset
// the table is swept to zero one entry per cycle, and busy stays high until
// the sweep ends. Configuration writes are always taken (cfg_ready is tied
// high) and must only be issued while no lookup is in flight.
module circular_table_interp_lookup (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire cti_pkg::in_word_t              in_word,
  output logic                                out_strobe,
  output cti_pkg::out_word_t                  out_word,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cti_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cti_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cti_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_POS,
    S_MOD,
    S_RDA,
    S_RDB,
    S_DIFF,
    S_FMUL,
    S_SUM,
    S_SCALE,
    S_ROUND
  } state_t;

  localparam logic signed [C_W-1:0] C_MAX = C_W'(8388607);
  localparam logic signed [C_W-1:0] C_MIN = -C_W'(8388608);

  state_t                     state_r;
  logic                       out_strobe_r;
  out_word_t                  out_word_r;
  logic signed [ANGLE_W-1:0]  angle_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic [FRAC_W-1:0]          frac_r;
  logic [TBL_AW-1:0]          ia_r;
  logic [TBL_AW-1:0]          ib_r;
  logic signed [ENTRY_W-1:0]  a_r;
  logic signed [DIFF_W-1:0]   diff_r;
  logic signed [V_W-1:0]      fm_r;
  logic signed [V8_W-1:0]     v8_r;
  logic signed [SC_W-1:0]     sc_r;

  cfg_regs_t                  regs;
  tbl_req_t                   tbl_req;
  logic [ENTRY_W-1:0]         rd_data;
  logic                       clr_done;
  mod_req_t                   mod_req;
  mod_rsp_t                   mod_rsp;

  logic                       accept;
  logic [P_W-1:0]             pos;
  logic [Q_W-1:0]             whole;
  logic [N_W-1:0]             ib_inc;
  logic [TBL_AW-1:0]          ib_c;
  logic [V_W-1:0]             v_c;
  logic signed [SC_W-1:0]     sc_round;
  logic signed [C_W-1:0]      c_full;
  logic [CORR_W-1:0]          corr_c;

  cti_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  cti_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (tbl_req),
    .rd_data  (rd_data),
    .clr_done (clr_done)
  );

  cti_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mod_req),
    .rsp   (mod_rsp)
  );

  assign busy       = (state_r != S_IDLE) || !clr_done;
  assign accept     = start && !busy;
  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  // Table position in Q.16 steps: the floored product plus the offset. Only
  // the low P_W bits matter, the value is known to fit.
  assign pos   = prod_r[FRAC_W +: P_W] + P_W'(regs.index_offset);
  assign whole = pos[P_W-1:FRAC_W];

  always_comb begin
    mod_req.start = (state_r == S_POS);
    mod_req.neg   = whole[Q_W-1];
    mod_req.mag   = whole[Q_W-1] ? MAG_W'(-whole) : MAG_W'(whole);
    mod_req.n     = regs.n_eff;
  end

  // Upper neighbor wraps to entry zero past the last entry in use.
  always_comb begin
    ib_inc = N_W'(mod_rsp.rem) + N_W'(1);
    if (ib_inc >= regs.n_eff) begin
      ib_c = '0;
    end else begin
      ib_c = TBL_AW'(ib_inc);
    end
  end

  // Single memory port: entry writes at acceptance, then the two reads.
  always_comb begin
    tbl_req.we    = accept && (in_word.opcode == OP_WRITE) &&
                    (int'(in_word.entry_index) < TABLE_DEPTH);
    tbl_req.wdata = in_word.entry_value;
    if (state_r == S_RDA) begin
      tbl_req.addr = ia_r;
    end else if (state_r == S_RDB) begin
      tbl_req.addr = ib_r;
    end else begin
      tbl_req.addr = TBL_AW'(in_word.entry_index);
    end
  end

  // Interpolated value a * 2^16 + f * (b - a), then rounding of the scaled
  // product and saturation to the correction range.
  always_comb begin
    v_c      = {{(V_W-ENTRY_W-FRAC_W){a_r[ENTRY_W-1]}}, a_r, {FRAC_W{1'b0}}} + fm_r;
    sc_round = sc_r + (SC_W'(1) <<< 31);
    c_full   = sc_round[SC_W-1 -: C_W];
    if (c_full > C_MAX) begin
      corr_c = CORR_W'(C_MAX);
    end else if (c_full < C_MIN) begin
      corr_c = CORR_W'(C_MIN);
    end else begin
      corr_c = CORR_W'(c_full);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (accept && (in_word.opcode == OP_LOOKUP)) begin
            angle_r <= in_word.angle;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          prod_r  <= PROD_W'(angle_r) * PROD_W'($signed({1'b0, regs.steps_per_radian}));
          state_r <= S_POS;
        end
        S_POS: begin
          frac_r  <= pos[FRAC_W-1:0];
          state_r <= S_MOD;
        end
        S_MOD: begin
          if (mod_rsp.done) begin
            ia_r    <= mod_rsp.rem;
            ib_r    <= ib_c;
            state_r <= S_RDA;
          end
        end
        S_RDA: begin
          state_r <= S_RDB;
        end
        S_RDB: begin
          a_r     <= $signed(rd_data);
          state_r <= S_DIFF;
        end
        S_DIFF: begin
          diff_r  <= DIFF_W'($signed(rd_data)) - DIFF_W'(a_r);
          state_r <= S_FMUL;
        end
        S_FMUL: begin
          fm_r    <= V_W'($signed({1'b0, frac_r})) * V_W'(diff_r);
          state_r <= S_SUM;
        end
        S_SUM: begin
          v8_r    <= $signed(v_c[8 +: V8_W]);
          state_r <= S_SCALE;
        end
        S_SCALE: begin
          sc_r    <= SC_W'(v8_r) * SC_W'($signed({1'b0, regs.output_scale}));
          state_r <= S_ROUND;
        end
        S_ROUND: begin
          out_word_r.correction <= $signed(corr_c);
          out_word_r.low_index  <= LIDX_W'(ia_r);
          out_strobe_r          <= 1'b1;
          state_r               <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire
